FILE: rtl/hsv_region_color_classifier_assert.svh
// Assertion macros shared by the HSV region color classifier RTL.
// The macros expect the including module to provide clock and reset.
`ifndef HSV_REGION_COLOR_CLASSIFIER_ASSERT_SVH
`define HSV_REGION_COLOR_CLASSIFIER_ASSERT_SVH

// Antecedent true implies consequent true in the same cycle.
`define HSVRCC_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("hsv classifier same-cycle check failed");

// Antecedent true implies consequent true in the next cycle.
`define HSVRCC_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("hsv classifier next-cycle check failed");

`endif

FILE: rtl/hsvrcc_pkg.sv
// Package for the HSV region color classifier: color codes, pixel thresholds,
// hue band limits, register indexes and the hue band decoder. No dependencies.
package hsvrcc_pkg;

   typedef enum logic [2:0] {
      COLOR_RED    = 3'd0,
      COLOR_ORANGE = 3'd1,
      COLOR_YELLOW = 3'd2,
      COLOR_GREEN  = 3'd3,
      COLOR_BLUE   = 3'd4,
      COLOR_WHITE  = 3'd5
   } color_type;

   localparam int NUM_BANDS = 5;

   localparam logic [7:0] NONGRAY_MIN = 8'd80;
   localparam logic [7:0] WHITE_MIN   = 8'd160;

   localparam logic [7:0] RED_LOW_MAX   = 8'd3;
   localparam logic [7:0] ORANGE_MIN    = 8'd4;
   localparam logic [7:0] ORANGE_MAX    = 8'd18;
   localparam logic [7:0] YELLOW_MAX    = 8'd39;
   localparam logic [7:0] GREEN_MAX     = 8'd76;
   localparam logic [7:0] BLUE_MAX      = 8'd136;
   localparam logic [7:0] RED_HIGH_MIN  = 8'd171;
   localparam logic [7:0] HUE_MAX       = 8'd179;

   localparam logic REG_SAT_THRESH  = 1'b0;
   localparam logic REG_WHITE_RATIO = 1'b1;

   localparam logic [7:0]  SAT_THRESH_RESET  = 8'd0;
   localparam logic [15:0] WHITE_RATIO_RESET = 16'd32768;

   typedef logic [NUM_BANDS-1:0] band_hit_type;

   // One-hot band membership of a hue; all zero when the hue is in no band.
   function automatic band_hit_type band_of(input logic [7:0] hue);
      band_hit_type hit;
      hit = '0;
      hit[COLOR_RED]    = (hue <= RED_LOW_MAX) || (hue >= RED_HIGH_MIN && hue <= HUE_MAX);
      hit[COLOR_ORANGE] = (hue >= ORANGE_MIN) && (hue <= ORANGE_MAX);
      hit[COLOR_YELLOW] = (hue > ORANGE_MAX) && (hue <= YELLOW_MAX);
      hit[COLOR_GREEN]  = (hue > YELLOW_MAX) && (hue <= GREEN_MAX);
      hit[COLOR_BLUE]   = (hue > GREEN_MAX) && (hue <= BLUE_MAX);
      return hit;
   endfunction

endpackage

FILE: rtl/hsv_region_color_classifier.sv
// HSV region color classifier: one color beat on rsp_valid for each accepted
// pixel beat with last_pixel set; one pixel per cycle while not held by rsp_stall.
// The pipeline is input register, counter bank, product/argmax, compare.
// The whole pipeline holds while an output beat waits under rsp_stall.
// Reset (synchronous, active high) clears all counters and valid bits and
// restores saturation_threshold to 0 and white_ratio to 32768.
`include "hsv_region_color_classifier_assert.svh"

module hsv_region_color_classifier #(
   parameter int COUNT_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   // Pixel channel.
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_hue,
   input  logic [7:0]  req_saturation,
   input  logic [7:0]  req_brightness,
   input  logic        req_last_pixel,
   // Result channel.
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_color,
   // Register port.
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam int NB = hsvrcc_pkg::NUM_BANDS;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   // Saturating increment shared by all counters.
   function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
      return (v == COUNT_MAX) ? v : v + COUNT_BITS'(1);
   endfunction

   // ---------------------------------------------------------------------
   // Write these registers only while the block is idle; the block does not enforce it.
   // ---------------------------------------------------------------------
   logic [7:0]  sat_thresh_ff;
   logic [15:0] white_ratio_ff;
   logic        csr_write;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         sat_thresh_ff  <= hsvrcc_pkg::SAT_THRESH_RESET;
         white_ratio_ff <= hsvrcc_pkg::WHITE_RATIO_RESET;
      end else if (csr_write) begin
         unique case (paddr[2])
            hsvrcc_pkg::REG_SAT_THRESH:  sat_thresh_ff  <= pwdata[7:0];
            hsvrcc_pkg::REG_WHITE_RATIO: white_ratio_ff <= pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[2])
         hsvrcc_pkg::REG_SAT_THRESH:  prdata = {24'd0, sat_thresh_ff};
         hsvrcc_pkg::REG_WHITE_RATIO: prdata = {16'd0, white_ratio_ff};
         default:                     prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------------
   // Flow control. Every stage moves together; the pipeline only holds when
   // a finished color beat sits in the output register and is stalled.
   // ---------------------------------------------------------------------
   logic rsp_valid_ff;
   logic advance;

   assign advance   = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !advance;

   // ---------------------------------------------------------------------
   // Stage 0: registered pixel.
   // ---------------------------------------------------------------------
   logic       pix_valid_ff;
   logic [7:0] pix_hue_ff;
   logic [7:0] pix_sat_ff;
   logic [7:0] pix_bright_ff;
   logic       pix_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pix_valid_ff <= 1'b0;
      end else if (advance) begin
         pix_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && req_valid) begin
         pix_hue_ff    <= req_hue;
         pix_sat_ff    <= req_saturation;
         pix_bright_ff <= req_brightness;
         pix_last_ff   <= req_last_pixel;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 1: counter bank. The counters fold in the registered pixel; on
   // the last pixel of a region the updated totals move to a snapshot and
   // the counters restart from zero, so the next region can follow at once.
   // ---------------------------------------------------------------------
   logic                      is_nongray;
   logic                      is_white;
   hsvrcc_pkg::band_hit_type  band_hit;

   logic [COUNT_BITS-1:0] nongray_ff, nongray_in;
   logic [COUNT_BITS-1:0] white_ff, white_in;
   logic [COUNT_BITS-1:0] band_ff [NB];
   logic [COUNT_BITS-1:0] band_in [NB];

   logic                  snap_valid_ff;
   logic [COUNT_BITS-1:0] snap_nongray_ff;
   logic [COUNT_BITS-1:0] snap_white_ff;
   logic [COUNT_BITS-1:0] snap_band_ff [NB];

   assign is_nongray = pix_bright_ff > hsvrcc_pkg::NONGRAY_MIN;
   assign is_white   = (pix_sat_ff <= sat_thresh_ff) && (pix_bright_ff > hsvrcc_pkg::WHITE_MIN);
   assign band_hit   = hsvrcc_pkg::band_of(pix_hue_ff);

   always_comb begin
      nongray_in = is_nongray ? sat_inc(nongray_ff) : nongray_ff;
      white_in   = is_white ? sat_inc(white_ff) : white_ff;
      for (int i = 0; i < NB; i++) begin
         band_in[i] = (is_nongray && band_hit[i]) ? sat_inc(band_ff[i]) : band_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nongray_ff    <= '0;
         white_ff      <= '0;
         snap_valid_ff <= 1'b0;
         for (int i = 0; i < NB; i++) begin
            band_ff[i] <= '0;
         end
      end else if (advance) begin
         snap_valid_ff <= pix_valid_ff && pix_last_ff;
         if (pix_valid_ff) begin
            if (pix_last_ff) begin
               nongray_ff <= '0;
               white_ff   <= '0;
               for (int i = 0; i < NB; i++) begin
                  band_ff[i] <= '0;
               end
            end else begin
               nongray_ff <= nongray_in;
               white_ff   <= white_in;
               for (int i = 0; i < NB; i++) begin
                  band_ff[i] <= band_in[i];
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance && pix_valid_ff && pix_last_ff) begin
         snap_nongray_ff <= nongray_in;
         snap_white_ff   <= white_in;
         for (int i = 0; i < NB; i++) begin
            snap_band_ff[i] <= band_in[i];
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stage 2: white_ratio * nongray_count product and the band argmax.
   // A later band wins only on strictly more evidence, so ties keep the
   // lowest color code and an empty region reports red.
   // ---------------------------------------------------------------------
   logic                      dec_valid_ff;
   logic [COUNT_BITS+15:0]    ratio_prod_ff, ratio_prod_in;
   logic [COUNT_BITS-1:0]     dec_white_ff;
   hsvrcc_pkg::color_type     best_color_ff, best_color_in;
   logic [COUNT_BITS-1:0]     best_count;

   assign ratio_prod_in = {{COUNT_BITS{1'b0}}, white_ratio_ff} * {16'd0, snap_nongray_ff};

   always_comb begin
      best_count    = snap_band_ff[0];
      best_color_in = hsvrcc_pkg::COLOR_RED;
      for (int i = 1; i < NB; i++) begin
         if (snap_band_ff[i] > best_count) begin
            best_count    = snap_band_ff[i];
            best_color_in = hsvrcc_pkg::color_type'(3'(i));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dec_valid_ff <= 1'b0;
      end else if (advance) begin
         dec_valid_ff <= snap_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && snap_valid_ff) begin
         ratio_prod_ff <= ratio_prod_in;
         dec_white_ff  <= snap_white_ff;
         best_color_ff <= best_color_in;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 3: white test and output register. white_count * 65536 is the
   // count shifted up by 16 bits; with no non-gray pixels the white count
   // is also zero, so the test is false as required.
   // ---------------------------------------------------------------------
   logic [COUNT_BITS+15:0] white_scaled;
   hsvrcc_pkg::color_type  rsp_color_ff, rsp_color_in;

   assign white_scaled = {dec_white_ff, 16'd0};
   assign rsp_color_in = (white_scaled > ratio_prod_ff) ? hsvrcc_pkg::COLOR_WHITE
                                                        : best_color_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= dec_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && dec_valid_ff) begin
         rsp_color_ff <= rsp_color_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_color = rsp_color_ff;

   // ---------------------------------------------------------------------
   // Assertions.
   // ---------------------------------------------------------------------
   // A white pixel is always bright enough to be non-gray, and both saturate
   // at the same ceiling, so the white count can never pass the other.
   `HSVRCC_ASSERT_SAME(a_white_le_nongray, 1'b1, white_ff <= nongray_ff)
   // Band evidence only comes from non-gray pixels.
   `HSVRCC_ASSERT_SAME(a_band0_le_nongray, 1'b1, band_ff[0] <= nongray_ff)
   `HSVRCC_ASSERT_SAME(a_band4_le_nongray, 1'b1, band_ff[4] <= nongray_ff)
   // Counters restart after the last pixel of a region is folded in.
   `HSVRCC_ASSERT_NEXT(a_clear_on_last, advance && pix_valid_ff && pix_last_ff,
                       nongray_ff == '0 && white_ff == '0)
   // A taken color beat is not shown again unless a new one was ready.
   `HSVRCC_ASSERT_NEXT(a_no_repeat, rsp_valid_ff && !rsp_stall && !dec_valid_ff,
                       !rsp_valid_ff)

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for hsv_region_color_classifier: streams HSV pixel regions
// and compares every color beat with an internal region color predictor.
// Depends on the RTL package hsvrcc_pkg and the block itself; nothing else.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   // Predictor of the classifier. It keeps its own copy of the two registers
   // and of the region counters, and queues one expected color per last pixel.
   class region_color_tracker;
      logic [7:0]  sat_limit;
      logic [15:0] white_frac;
      logic [15:0] nongray_cnt;
      logic [15:0] white_cnt;
      logic [15:0] band_cnt[hsvrcc_pkg::NUM_BANDS];
      hsvrcc_pkg::color_type color_queue[$];
      int          errors;
      int          pixels;
      int          regions;

      function new();
         sat_limit  = hsvrcc_pkg::SAT_THRESH_RESET;
         white_frac = hsvrcc_pkg::WHITE_RATIO_RESET;
         errors     = 0;
         pixels     = 0;
         regions    = 0;
         clear_counts();
      endfunction

      function void clear_counts();
         nongray_cnt = '0;
         white_cnt   = '0;
         foreach (band_cnt[i]) band_cnt[i] = '0;
      endfunction

      // Counters stick at all ones.
      function logic [15:0] bump(logic [15:0] cnt);
         return (cnt == 16'hFFFF) ? cnt : cnt + 16'd1;
      endfunction

      // Band of a hue, or -1 for the gap between blue and red and for hues past 179.
      function int hue_band(logic [7:0] h);
         if (h <= hsvrcc_pkg::RED_LOW_MAX ||
             (h >= hsvrcc_pkg::RED_HIGH_MIN && h <= hsvrcc_pkg::HUE_MAX))
            return hsvrcc_pkg::COLOR_RED;
         if (h >= hsvrcc_pkg::ORANGE_MIN && h <= hsvrcc_pkg::ORANGE_MAX)
            return hsvrcc_pkg::COLOR_ORANGE;
         if (h > hsvrcc_pkg::ORANGE_MAX && h <= hsvrcc_pkg::YELLOW_MAX)
            return hsvrcc_pkg::COLOR_YELLOW;
         if (h > hsvrcc_pkg::YELLOW_MAX && h <= hsvrcc_pkg::GREEN_MAX)
            return hsvrcc_pkg::COLOR_GREEN;
         if (h > hsvrcc_pkg::GREEN_MAX && h <= hsvrcc_pkg::BLUE_MAX)
            return hsvrcc_pkg::COLOR_BLUE;
         return -1;
      endfunction

      function void set_reg(logic idx, logic [31:0] value);
         case (idx)
            hsvrcc_pkg::REG_SAT_THRESH:  sat_limit  = value[7:0];
            hsvrcc_pkg::REG_WHITE_RATIO: white_frac = value[15:0];
         endcase
      endfunction

      function logic [31:0] reg_value(logic idx);
         return (idx == hsvrcc_pkg::REG_SAT_THRESH) ? {24'd0, sat_limit}
                                                    : {16'd0, white_frac};
      endfunction

      function int pending();
         return color_queue.size();
      endfunction

      function void note_pixel(logic [7:0] h, logic [7:0] s, logic [7:0] b, logic last);
         int                    band;
         longint unsigned       white_side;
         longint unsigned       ratio_side;
         logic [15:0]           best;
         hsvrcc_pkg::color_type pick;
         pixels++;
         if (b > hsvrcc_pkg::NONGRAY_MIN) begin
            nongray_cnt = bump(nongray_cnt);
            band = hue_band(h);
            if (band >= 0) band_cnt[band] = bump(band_cnt[band]);
         end
         if (s <= sat_limit && b > hsvrcc_pkg::WHITE_MIN) white_cnt = bump(white_cnt);
         if (!last) return;
         white_side = 64'(white_cnt);
         white_side = white_side << 16;
         ratio_side = 64'(white_frac);
         ratio_side = ratio_side * 64'(nongray_cnt);
         if (white_side > ratio_side) begin
            pick = hsvrcc_pkg::COLOR_WHITE;
         end else begin
            pick = hsvrcc_pkg::COLOR_RED;
            best = band_cnt[0];
            for (int i = 1; i < hsvrcc_pkg::NUM_BANDS; i++) begin
               if (band_cnt[i] > best) begin
                  best = band_cnt[i];
                  pick = hsvrcc_pkg::color_type'(3'(i));
               end
            end
         end
         color_queue.push_back(pick);
         clear_counts();
      endfunction

      function void check_color(logic [2:0] got);
         hsvrcc_pkg::color_type want;
         if (color_queue.size() == 0) begin
            errors++;
            $error("color beat with no region pending: color actual %0d", got);
            return;
         end
         want = color_queue.pop_front();
         regions++;
         if (got !== want) begin
            errors++;
            $error("color mismatch: expected %0d (%s), actual %0d", want, want.name(), got);
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_hue;
   logic [7:0]  req_saturation;
   logic [7:0]  req_brightness;
   logic        req_last_pixel;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [2:0]  rsp_color;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [2:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   region_color_tracker tracker;

   // Random idling on both sides is enabled per phase; the receiver also takes
   // one long hold-off request from the main sequence.
   bit idle_on;
   int hold_cycles;
   int settings_used;

   hsv_region_color_classifier i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_hue        (req_hue),
      .req_saturation (req_saturation),
      .req_brightness (req_brightness),
      .req_last_pixel (req_last_pixel),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_color      (rsp_color),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Safety net: the slowest correct run is well under a millisecond of
   // simulated time, so this only fires when the block hangs.
   initial begin
      #4000000;
      $display("DONE: errors detected");
      $finish;
   end

   // Receiver side. Stall changes only at the falling edge. A long hold-off,
   // when requested, lets the pipeline fill so that the block stalls its input.
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold_cycles) @(negedge clock);
            hold_cycles = 0;
            rsp_stall <= 1'b0;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 13)) @(negedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // Every accepted color beat goes straight to the predictor for checking.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) tracker.check_color(rsp_color);
   end

   // One register port transfer: setup cycle, then access cycle until pready,
   // then the port goes idle. Called and returns at a falling edge.
   task automatic csr_access(input logic idx, input logic wr, input logic [31:0] wdata,
                             output logic [31:0] rdata);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= wr;
      paddr   <= {idx, 2'b00};
      pwdata  <= wdata;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      rdata = prdata;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clock);
   endtask

   // Reads a register back and compares it with the predictor's copy.
   task automatic verify_register(input logic idx);
      logic [31:0] got;
      csr_access(idx, 1'b0, '0, got);
      if (got !== tracker.reg_value(idx)) begin
         tracker.errors++;
         $error("register %0d readback mismatch: expected %0d, actual %0d",
                idx, tracker.reg_value(idx), got);
      end
   endtask

   task automatic set_register(input logic idx, input logic [31:0] value);
      logic [31:0] unused;
      csr_access(idx, 1'b1, value, unused);
      tracker.set_reg(idx, value);
      verify_register(idx);
   endtask

   task automatic configure(input logic [7:0] thresh, input logic [15:0] ratio);
      set_register(hsvrcc_pkg::REG_SAT_THRESH, {24'd0, thresh});
      set_register(hsvrcc_pkg::REG_WHITE_RATIO, {16'd0, ratio});
      settings_used++;
   endtask

   // Offers one pixel beat and returns at the falling edge after it was taken.
   // With idling on, valid may first drop for a random burst.
   task automatic send_pixel(input logic [7:0] h, input logic [7:0] s,
                             input logic [7:0] b, input logic last);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_hue        <= h;
      req_saturation <= s;
      req_brightness <= b;
      req_last_pixel <= last;
      do @(posedge clock); while (req_stall);
      tracker.note_pixel(h, s, b, last);
      @(negedge clock);
   endtask

   // Drops valid and waits until every region has reported, then waits for
   // the pipeline to empty, so that a register write finds the block idle.
   task automatic drain();
      req_valid <= 1'b0;
      while (tracker.pending() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   // Random regions. Half the pixels of a region sit at or just above a favored
   // hue so that one band tends to lead; brightness and saturation cluster around the
   // gray, white and saturation limits to hit the compares at their edges.
   task automatic random_regions(input int pixel_budget);
      int         sent;
      int         len;
      int         favored;
      int         near_sat;
      logic [7:0] h;
      logic [7:0] s;
      logic [7:0] b;
      sent = 0;
      while (sent < pixel_budget) begin
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
         favored = $urandom_range(0, hsvrcc_pkg::HUE_MAX);
         for (int i = 0; i < len; i++) begin
            case ($urandom_range(0, 9))
               0:       h = 8'($urandom_range(hsvrcc_pkg::HUE_MAX + 1, 255));
               1:       h = 8'($urandom_range(hsvrcc_pkg::BLUE_MAX, hsvrcc_pkg::RED_HIGH_MIN));
               2, 3, 4: h = 8'(favored);
               5, 6:    h = 8'(favored + int'($urandom_range(0, 4)));
               default: h = 8'($urandom_range(0, hsvrcc_pkg::HUE_MAX));
            endcase
            case ($urandom_range(0, 3))
               0:       b = 8'(hsvrcc_pkg::NONGRAY_MIN + $urandom_range(0, 1));
               1:       b = 8'(hsvrcc_pkg::WHITE_MIN + $urandom_range(0, 1));
               default: b = 8'($urandom_range(0, 255));
            endcase
            if ($urandom_range(0, 2) == 0) begin
               near_sat = int'(tracker.sat_limit) + int'($urandom_range(0, 2)) - 1;
               if (near_sat < 0) near_sat = 0;
               if (near_sat > 255) near_sat = 255;
               s = 8'(near_sat);
            end else begin
               s = 8'($urandom_range(0, 255));
            end
            send_pixel(h, s, b, i == len - 1);
         end
         sent += len;
      end
   endtask

   initial begin
      int band_edges[16] = '{0, 3, 4, 18, 19, 39, 40, 76, 77, 136, 137, 170, 171, 179,
                             180, 255};
      tracker        = new();
      idle_on        = 1'b0;
      hold_cycles    = 0;
      settings_used  = 1;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_hue        = '0;
      req_saturation = '0;
      req_brightness = '0;
      req_last_pixel = 1'b0;
      psel           = 1'b0;
      penable        = 1'b0;
      pwrite         = 1'b0;
      paddr          = '0;
      pwdata         = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // The registers must come out of reset at their documented values.
      verify_register(hsvrcc_pkg::REG_SAT_THRESH);
      verify_register(hsvrcc_pkg::REG_WHITE_RATIO);

      // Directed part under the reset settings (threshold 0, ratio one half).
      idle_on = 1'b1;
      // A region of one dark pixel has no non-gray pixels: the white test
      // fails and no band has evidence, so it reports red.
      send_pixel(8'd60, 8'd0, 8'd0, 1'b1);
      // Single bright, saturated pixels on both sides of every band edge,
      // including the gap between blue and red and hues past the top.
      foreach (band_edges[i]) send_pixel(8'(band_edges[i]), 8'd255, 8'd255, 1'b1);
      // Brightness exactly at the gray limit does not count; one above does.
      send_pixel(8'd50, 8'd255, hsvrcc_pkg::NONGRAY_MIN, 1'b0);
      send_pixel(8'd100, 8'd255, hsvrcc_pkg::NONGRAY_MIN + 8'd1, 1'b1);
      // White needs brightness above its limit, not at it.
      send_pixel(8'd50, 8'd0, hsvrcc_pkg::WHITE_MIN + 8'd1, 1'b1);
      send_pixel(8'd50, 8'd0, hsvrcc_pkg::WHITE_MIN, 1'b1);
      // Equal evidence in orange and blue: the lower code wins.
      send_pixel(8'd100, 8'd128, 8'd200, 1'b0);
      send_pixel(8'd10, 8'd127, 8'd200, 1'b1);
      drain();

      // Register extremes: every bright pixel is white and any white wins,
      // then the narrowest white test with the highest ratio.
      configure(8'd255, 16'd0);
      random_regions(80);
      drain();
      configure(8'd0, 16'd65535);
      random_regions(80);
      drain();

      // Back pressure: the receiver holds off for a long stretch while pixels
      // keep coming, so a waiting color beat freezes the pipeline.
      configure(8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)));
      hold_cycles = 250;
      random_regions(80);
      drain();

      for (int p = 0; p < 2; p++) begin
         configure(8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)));
         random_regions(80);
         drain();
      end

      // Final stretch at full rate on both sides.
      idle_on = 1'b0;
      configure(8'($urandom_range(0, 255)), 16'($urandom_range(16384, 49152)));
      random_regions(80);
      drain();

      $display("Run covered %0d pixel beats and %0d color beats over %0d register settings,",
               tracker.pixels, tracker.regions, settings_used);
      $display("including band edges, register extremes and a long output hold-off.");
      if (tracker.errors == 0 && tracker.pending() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
